### sv/fls_pkg.sv
// Shared types and constants for the frequency limit residency statistics block.
// Holds field widths, item and status codes, controller states and interface structs.
// No dependencies.
`default_nettype none

package fls_pkg;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 4;
  localparam int FREQ_W  = 24;
  localparam int TIME_W  = 32;
  localparam int RES_W   = 64;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SKIP    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FRD,
    S_FWR,
    S_CRD,
    S_CWR,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [RES_W-1:0]   floor_dwell;
    logic [COUNT_W-1:0] floor_changes;
    logic [RES_W-1:0]   ceiling_dwell;
    logic [COUNT_W-1:0] ceiling_changes;
  } stats_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } stats_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FREQ_W-1:0] frequency;
    stats_t            stats;
  } result_t;

endpackage

`default_nettype wire

### sv/fls_freq_mem.sv
// Frequency table memory: one synchronous port, registered read data.
// Contents are undefined until written. Depends on fls_pkg.
`default_nettype none

module fls_freq_mem #(
  parameter int ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic                             rd_en,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] addr,
  input  wire logic [fls_pkg::FREQ_W-1:0]       wr_data,
  output logic      [fls_pkg::FREQ_W-1:0]       rd_data
);

  logic [fls_pkg::FREQ_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### sv/fls_stats_mem.sv
// Statistics memory: residency times and change counts per table entry.
// Per-entry valid bits make unwritten entries read as zero after reset. Depends on fls_pkg.
`default_nettype none

module fls_stats_mem #(
  parameter int ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fls_pkg::stats_cmd_t cmd,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] addr,
  input  wire fls_pkg::stats_t     wr_data,
  output fls_pkg::stats_t          rd_data
);

  fls_pkg::stats_t      mem [ENTRIES];
  logic [ENTRIES-1:0]   valid;
  fls_pkg::stats_t      rd_raw;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_raw <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.wr) begin
        valid[addr] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_valid <= valid[addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

### sv/fls_ctrl.sv
// Controller: accepts requests, scans the frequency table and performs the
// read-modify-write of the statistics memory. Depends on fls_pkg.
`default_nettype none

module fls_ctrl #(
  parameter int ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [fls_pkg::KIND_W-1:0]     kind,
  input  wire logic [fls_pkg::INDEX_W-1:0]    entry_index,
  input  wire logic [fls_pkg::FREQ_W-1:0]     min_limit,
  input  wire logic [fls_pkg::FREQ_W-1:0]     max_limit,
  input  wire logic [fls_pkg::TIME_W-1:0]     timestamp,
  input  wire logic [fls_pkg::CFG_W-1:0]      entry_count,
  output logic                                freq_wr_en,
  output logic                                freq_rd_en,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] freq_addr,
  input  wire logic [fls_pkg::FREQ_W-1:0]     freq_rd_data,
  output fls_pkg::stats_cmd_t                 stats_cmd,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] stats_addr,
  output fls_pkg::stats_t                     stats_wr_data,
  input  wire fls_pkg::stats_t                stats_rd_data,
  input  wire logic                           out_free,
  output logic                                res_push,
  output fls_pkg::result_t                    res
);

  localparam int IDX_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int LIM_W  = $clog2(ENTRIES + 1);
  localparam int CW     = LIM_W > fls_pkg::CFG_W ? LIM_W : fls_pkg::CFG_W;

  fls_pkg::state_t state, state_next;

  logic [fls_pkg::FREQ_W-1:0] cur_floor;
  logic [fls_pkg::FREQ_W-1:0] cur_ceil;
  logic [fls_pkg::TIME_W-1:0] last_time;
  logic [fls_pkg::FREQ_W-1:0] new_min;
  logic [fls_pkg::FREQ_W-1:0] new_max;
  logic [fls_pkg::TIME_W-1:0] now;
  logic [fls_pkg::TIME_W-1:0] delta;
  logic [CW-1:0]              scan_cnt;
  logic [CW-1:0]              limit;
  logic                       pend;
  logic [IDX_W-1:0]           pend_addr;
  logic                       f_found;
  logic                       c_found;
  logic [IDX_W-1:0]           f_idx;
  logic [IDX_W-1:0]           c_idx;
  logic                       idx_ok;
  logic                       unchanged;
  logic                       accept;
  logic [IDX_W-1:0]           in_addr;

  assign limit     = (CW'(entry_count) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(entry_count);
  assign idx_ok    = int'(entry_index) < ENTRIES;
  assign in_addr   = IDX_W'(entry_index);
  assign unchanged = (cur_floor == min_limit) && (cur_ceil == max_limit);
  assign in_stall  = state != fls_pkg::S_IDLE;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    freq_wr_en = 1'b0;
    freq_rd_en = 1'b0;
    freq_addr  = in_addr;
    stats_cmd  = '0;
    stats_addr = f_idx;
    res_push   = 1'b0;
    case (state)
      fls_pkg::S_IDLE: begin
        if (in_valid) begin
          case (fls_pkg::kind_t'(kind))
            fls_pkg::KIND_LOAD: begin
              freq_wr_en = idx_ok;
              state_next = fls_pkg::S_DONE;
            end
            fls_pkg::KIND_UPDATE: begin
              state_next = unchanged ? fls_pkg::S_DONE : fls_pkg::S_SCAN;
            end
            fls_pkg::KIND_READ: begin
              if (idx_ok) begin
                freq_rd_en   = 1'b1;
                stats_cmd.rd = 1'b1;
                stats_addr   = in_addr;
                state_next   = fls_pkg::S_READ;
              end else begin
                state_next = fls_pkg::S_DONE;
              end
            end
            default: begin
              state_next = fls_pkg::S_DONE;
            end
          endcase
        end
      end
      fls_pkg::S_SCAN: begin
        freq_addr = scan_cnt[IDX_W-1:0];
        if (scan_cnt < limit) begin
          freq_rd_en = 1'b1;
        end else if (!pend) begin
          state_next = (f_found && c_found) ? fls_pkg::S_FRD : fls_pkg::S_DONE;
        end
      end
      fls_pkg::S_FRD: begin
        stats_cmd.rd = 1'b1;
        stats_addr   = f_idx;
        state_next   = fls_pkg::S_FWR;
      end
      fls_pkg::S_FWR: begin
        stats_cmd.wr = 1'b1;
        stats_addr   = f_idx;
        state_next   = fls_pkg::S_CRD;
      end
      fls_pkg::S_CRD: begin
        stats_cmd.rd = 1'b1;
        stats_addr   = c_idx;
        state_next   = fls_pkg::S_CWR;
      end
      fls_pkg::S_CWR: begin
        stats_cmd.wr = 1'b1;
        stats_addr   = c_idx;
        state_next   = fls_pkg::S_DONE;
      end
      fls_pkg::S_READ: begin
        state_next = fls_pkg::S_DONE;
      end
      fls_pkg::S_DONE: begin
        if (out_free) begin
          res_push   = 1'b1;
          state_next = fls_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fls_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    stats_wr_data = stats_rd_data;
    if (state == fls_pkg::S_FWR) begin
      stats_wr_data.floor_dwell = stats_rd_data.floor_dwell
                                  + fls_pkg::RES_W'(delta);
      stats_wr_data.floor_changes = stats_rd_data.floor_changes
                                    + fls_pkg::COUNT_W'(new_min != cur_floor);
    end else begin
      stats_wr_data.ceiling_dwell = stats_rd_data.ceiling_dwell
                                    + fls_pkg::RES_W'(delta);
      stats_wr_data.ceiling_changes = stats_rd_data.ceiling_changes
                                      + fls_pkg::COUNT_W'(new_max != cur_ceil);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_floor <= '0;
      cur_ceil  <= '0;
      last_time <= '0;
      pend      <= 1'b0;
    end else begin
      if (accept) begin
        new_min       <= min_limit;
        new_max       <= max_limit;
        now           <= timestamp;
        res.status    <= (fls_pkg::kind_t'(kind) == fls_pkg::KIND_UPDATE && unchanged)
                         ? fls_pkg::STAT_SKIP : fls_pkg::STAT_DONE;
        res.frequency <= '0;
        res.stats     <= '0;
        scan_cnt      <= '0;
        pend          <= 1'b0;
        f_found       <= 1'b0;
        c_found       <= 1'b0;
        if (fls_pkg::kind_t'(kind) == fls_pkg::KIND_START) begin
          cur_floor <= min_limit;
          cur_ceil  <= max_limit;
          last_time <= timestamp;
        end
      end
      if (state == fls_pkg::S_SCAN) begin
        pend      <= freq_rd_en;
        pend_addr <= scan_cnt[IDX_W-1:0];
        if (freq_rd_en) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
        if (pend) begin
          if (!f_found && freq_rd_data == cur_floor) begin
            f_found <= 1'b1;
            f_idx   <= pend_addr;
          end
          if (!c_found && freq_rd_data == cur_ceil) begin
            c_found <= 1'b1;
            c_idx   <= pend_addr;
          end
        end
        if (!freq_rd_en && !pend && !(f_found && c_found)) begin
          res.status <= fls_pkg::STAT_MISSING;
        end
        delta <= (now > last_time) ? now - last_time : '0;
      end
      if (state == fls_pkg::S_CWR) begin
        cur_floor <= new_min;
        cur_ceil  <= new_max;
        last_time <= now;
      end
      if (state == fls_pkg::S_READ) begin
        res.frequency <= freq_rd_data;
        res.stats     <= stats_rd_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    !(stats_cmd.rd && stats_cmd.wr))
    else $error("Statistics memory read and write issued together.");

  a_wr_needs_match: assert property (@(posedge clk) disable iff (rst)
    stats_cmd.wr |-> (f_found && c_found))
    else $error("Statistics written without both limits found.");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_free)
    else $error("Result pushed into a full output register.");

  a_idle_after_push: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !in_stall)
    else $error("Controller not idle after delivering a result.");
`endif

endmodule

`default_nettype wire

### sv/frequency_limit_residency_stats_top.sv
// Top level of the frequency limit residency statistics block.
// Holds the entry count register and the output register. Depends on fls_pkg,
// fls_freq_mem, fls_stats_mem and fls_ctrl.
`default_nettype none

// One request is handled at a time and each gives one result. Load, start,
// a read of an entry outside the table and an update whose limits are
// unchanged go straight to the done state; a read of an entry inside the
// table first passes a read state. Any other update scans the frequency memory
// one entry per cycle up to n, the entry count capped at ENTRIES, then, if both
// old limits are found, does two read-modify-write passes on the statistics
// memory. Every request ends in the done state, which waits while the previous
// result keeps the output register full under out_stall. A new request is taken
// while the previous result still waits in the output register.
module frequency_limit_residency_stats_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [fls_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fls_pkg::KIND_W-1:0]   kind,
  input  wire logic [fls_pkg::INDEX_W-1:0]  entry_index,
  input  wire logic [fls_pkg::FREQ_W-1:0]   entry_frequency,
  input  wire logic [fls_pkg::FREQ_W-1:0]   min_limit,
  input  wire logic [fls_pkg::FREQ_W-1:0]   max_limit,
  input  wire logic [fls_pkg::TIME_W-1:0]   timestamp,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fls_pkg::STAT_W-1:0]        status,
  output logic [fls_pkg::FREQ_W-1:0]        frequency,
  output logic [fls_pkg::RES_W-1:0]         floor_dwell,
  output logic [fls_pkg::COUNT_W-1:0]       floor_changes,
  output logic [fls_pkg::RES_W-1:0]         ceiling_dwell,
  output logic [fls_pkg::COUNT_W-1:0]       ceiling_changes
);

  localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  logic [fls_pkg::CFG_W-1:0]  entry_count;
  logic                       freq_wr_en;
  logic                       freq_rd_en;
  logic [IDX_W-1:0]           freq_addr;
  logic [fls_pkg::FREQ_W-1:0] freq_rd_data;
  fls_pkg::stats_cmd_t        stats_cmd;
  logic [IDX_W-1:0]           stats_addr;
  fls_pkg::stats_t            stats_wr_data;
  fls_pkg::stats_t            stats_rd_data;
  logic                       out_free;
  logic                       res_push;
  fls_pkg::result_t           res;
  fls_pkg::result_t           out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  fls_freq_mem #(.ENTRIES(ENTRIES)) u_freq_mem (
    .clk     (clk),
    .wr_en   (freq_wr_en),
    .rd_en   (freq_rd_en),
    .addr    (freq_addr),
    .wr_data (entry_frequency),
    .rd_data (freq_rd_data)
  );

  fls_stats_mem #(.ENTRIES(ENTRIES)) u_stats_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (stats_cmd),
    .addr    (stats_addr),
    .wr_data (stats_wr_data),
    .rd_data (stats_rd_data)
  );

  fls_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .entry_index   (entry_index),
    .min_limit     (min_limit),
    .max_limit     (max_limit),
    .timestamp     (timestamp),
    .entry_count   (entry_count),
    .freq_wr_en    (freq_wr_en),
    .freq_rd_en    (freq_rd_en),
    .freq_addr     (freq_addr),
    .freq_rd_data  (freq_rd_data),
    .stats_cmd     (stats_cmd),
    .stats_addr    (stats_addr),
    .stats_wr_data (stats_wr_data),
    .stats_rd_data (stats_rd_data),
    .out_free      (out_free),
    .res_push      (res_push),
    .res           (res)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_reg <= res;
    end
  end

  assign status          = out_reg.status;
  assign frequency       = out_reg.frequency;
  assign floor_dwell     = out_reg.stats.floor_dwell;
  assign floor_changes   = out_reg.stats.floor_changes;
  assign ceiling_dwell   = out_reg.stats.ceiling_dwell;
  assign ceiling_changes = out_reg.stats.ceiling_changes;

endmodule

`default_nettype wire
